FILE: design/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the tangent basis block
// Field widths, arithmetic widths, the triangle record and the state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

    // field widths
    localparam int POS_W     = 32;
    localparam int UV_W      = 18;
    localparam int NRM_W     = 16;
    localparam int OUT_W     = 32;

    // arithmetic widths
    localparam int EDGE_W    = POS_W + 1;
    localparam int DUV_W     = UV_W + 1;
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = DUV_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DET_W     = 39;
    localparam int NUM_W     = 53;
    localparam int UV_FRAC   = 16;
    localparam int NORM_FRAC = 14;
    localparam int QUO_W     = 32;
    localparam int CNT_W     = $clog2(QUO_W);

    // one triangle: edges, UV deltas and the closing corner's normal
    typedef struct packed {
        logic signed [EDGE_W-1:0] e1_x;
        logic signed [EDGE_W-1:0] e1_y;
        logic signed [EDGE_W-1:0] e1_z;
        logic signed [EDGE_W-1:0] e2_x;
        logic signed [EDGE_W-1:0] e2_y;
        logic signed [EDGE_W-1:0] e2_z;
        logic signed [DUV_W-1:0]  du1;
        logic signed [DUV_W-1:0]  dv1;
        logic signed [DUV_W-1:0]  du2;
        logic signed [DUV_W-1:0]  dv2;
        logic signed [NRM_W-1:0]  n_x;
        logic signed [NRM_W-1:0]  n_y;
        logic signed [NRM_W-1:0]  n_z;
    } tri_rec_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // corner position within the current triangle
    typedef enum logic [1:0] {
        CNR_FIRST  = 2'd0,
        CNR_SECOND = 2'd1,
        CNR_THIRD  = 2'd2
    } corner_t;

    // back-end sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_EVAL,
        ST_DIV,
        ST_DIV_END,
        ST_PMUL,
        ST_PACC,
        ST_OUT
    } back_state_t;

    localparam logic [2:0] TERM_DET  = 3'd0;
    localparam logic [2:0] TERM_LAST = 3'd6;
    localparam logic [2:0] TERM_BIT0 = 3'd4;

endpackage

`default_nettype wire

FILE: design/ttb_if.sv
// ----------------------------------------------------------------------------
// ttb_if: channel interfaces of the tangent basis block
// Corner items in, basis items out, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttb_corner_if;
    logic                               valid;
    logic                               ready;
    logic signed [ttb_pkg::POS_W-1:0]   pos_x;
    logic signed [ttb_pkg::POS_W-1:0]   pos_y;
    logic signed [ttb_pkg::POS_W-1:0]   pos_z;
    logic signed [ttb_pkg::UV_W-1:0]    tex_u;
    logic signed [ttb_pkg::UV_W-1:0]    tex_v;
    logic signed [ttb_pkg::NRM_W-1:0]   norm_x;
    logic signed [ttb_pkg::NRM_W-1:0]   norm_y;
    logic signed [ttb_pkg::NRM_W-1:0]   norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, output ready);
endinterface

interface ttb_basis_if;
    logic                               valid;
    logic                               ready;
    logic signed [ttb_pkg::OUT_W-1:0]   tangent_x;
    logic signed [ttb_pkg::OUT_W-1:0]   tangent_y;
    logic signed [ttb_pkg::OUT_W-1:0]   tangent_z;
    logic signed [ttb_pkg::OUT_W-1:0]   bitangent_x;
    logic signed [ttb_pkg::OUT_W-1:0]   bitangent_y;
    logic signed [ttb_pkg::OUT_W-1:0]   bitangent_z;
    logic                               degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, output ready);
endinterface

`default_nettype wire

FILE: design/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front: corner intake
// Keeps the first two corners and pushes a triangle record on the third.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ttb_corner_if.sink              corner,
    input  wire ttb_pkg::q_status_t q_status,
    output logic                    push,
    output ttb_pkg::tri_rec_t       push_rec
);

    ttb_pkg::corner_t                  cnr_reg, cnr_next;
    logic signed [ttb_pkg::POS_W-1:0]  p0_x_reg, p0_y_reg, p0_z_reg;
    logic signed [ttb_pkg::POS_W-1:0]  p1_x_reg, p1_y_reg, p1_z_reg;
    logic signed [ttb_pkg::UV_W-1:0]   u0_reg, v0_reg, u1_reg, v1_reg;
    logic                              accept;

    // stall only the closing corner when the queue is full
    assign corner.ready = (cnr_reg != ttb_pkg::CNR_THIRD) || !q_status.full;
    assign accept       = corner.valid && corner.ready;
    assign push         = accept && (cnr_reg == ttb_pkg::CNR_THIRD);

    // advance the corner position
    always_comb
    begin
        cnr_next = cnr_reg;
        if (accept)
        begin
            unique case (cnr_reg)
                ttb_pkg::CNR_SECOND: cnr_next = ttb_pkg::CNR_THIRD;
                ttb_pkg::CNR_THIRD:  cnr_next = ttb_pkg::CNR_FIRST;
                default:             cnr_next = ttb_pkg::CNR_SECOND;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnr_reg <= ttb_pkg::CNR_FIRST;
        end
        else
        begin
            cnr_reg <= cnr_next;
        end
    end

    // hold the first two corners
    always_ff @(posedge clk)
    begin
        if (accept && cnr_reg == ttb_pkg::CNR_SECOND)
        begin
            p1_x_reg <= corner.pos_x;
            p1_y_reg <= corner.pos_y;
            p1_z_reg <= corner.pos_z;
            u1_reg   <= corner.tex_u;
            v1_reg   <= corner.tex_v;
        end
        else if (accept && cnr_reg != ttb_pkg::CNR_THIRD)
        begin
            p0_x_reg <= corner.pos_x;
            p0_y_reg <= corner.pos_y;
            p0_z_reg <= corner.pos_z;
            u0_reg   <= corner.tex_u;
            v0_reg   <= corner.tex_v;
        end
    end

    // form edges and UV deltas of the closing corner
    always_comb
    begin
        push_rec.e1_x = ttb_pkg::EDGE_W'(p1_x_reg) - ttb_pkg::EDGE_W'(p0_x_reg);
        push_rec.e1_y = ttb_pkg::EDGE_W'(p1_y_reg) - ttb_pkg::EDGE_W'(p0_y_reg);
        push_rec.e1_z = ttb_pkg::EDGE_W'(p1_z_reg) - ttb_pkg::EDGE_W'(p0_z_reg);
        push_rec.e2_x = ttb_pkg::EDGE_W'(corner.pos_x) - ttb_pkg::EDGE_W'(p0_x_reg);
        push_rec.e2_y = ttb_pkg::EDGE_W'(corner.pos_y) - ttb_pkg::EDGE_W'(p0_y_reg);
        push_rec.e2_z = ttb_pkg::EDGE_W'(corner.pos_z) - ttb_pkg::EDGE_W'(p0_z_reg);
        push_rec.du1  = ttb_pkg::DUV_W'(u1_reg) - ttb_pkg::DUV_W'(u0_reg);
        push_rec.dv1  = ttb_pkg::DUV_W'(v1_reg) - ttb_pkg::DUV_W'(v0_reg);
        push_rec.du2  = ttb_pkg::DUV_W'(corner.tex_u) - ttb_pkg::DUV_W'(u0_reg);
        push_rec.dv2  = ttb_pkg::DUV_W'(corner.tex_v) - ttb_pkg::DUV_W'(v0_reg);
        push_rec.n_x  = corner.norm_x;
        push_rec.n_y  = corner.norm_y;
        push_rec.n_z  = corner.norm_z;
    end

endmodule

`default_nettype wire

FILE: design/ttb_queue.sv
// ----------------------------------------------------------------------------
// ttb_queue: two-entry triangle queue
// Decouples corner intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ttb_pkg::tri_rec_t  push_rec,
    input  wire logic               pop,
    output ttb_pkg::tri_rec_t       pop_rec,
    output ttb_pkg::q_status_t      q_status
);

    ttb_pkg::tri_rec_t  store_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         fill_reg, fill_next;

    assign q_status.full  = (fill_reg == 2'd2);
    assign q_status.empty = (fill_reg == 2'd0);
    assign pop_rec        = store_reg[rd_ptr_reg];

    // track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    // write entry
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

FILE: design/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back: arithmetic sequencer
// Shared multiplier, bit-serial divider and projection for one triangle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ttb_pkg::q_status_t q_status,
    input  wire ttb_pkg::tri_rec_t  pop_rec,
    output logic                    pop,
    ttb_basis_if.source             basis
);

    localparam int AW = ttb_pkg::MUL_A_W;
    localparam int BW = ttb_pkg::MUL_B_W;
    localparam int PW = ttb_pkg::PROD_W;
    localparam int DW = ttb_pkg::DET_W;
    localparam int OW = ttb_pkg::OUT_W;
    localparam int QW = ttb_pkg::QUO_W;
    localparam int FR = ttb_pkg::UV_FRAC;

    ttb_pkg::back_state_t     state_reg, state_next;
    ttb_pkg::tri_rec_t        rec_reg;
    logic [2:0]               term_reg;
    logic                     half_reg;
    logic signed [PW-1:0]     prod_reg, acc_reg, prod_full, dot_sum, corr, diff;
    logic [DW-1:0]            det_mag_reg, rem_reg;
    logic                     det_neg_reg, num_neg_reg, ovf_reg, degen_reg;
    logic [QW-1:0]            div_sh_reg;
    logic [ttb_pkg::CNT_W-1:0] cnt_reg;
    logic signed [OW-1:0]     res_reg [6];
    logic [1:0]               pidx_reg;
    logic                     pass_reg;
    logic signed [AW-1:0]     d_reg;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic [2:0]               res_idx;
    logic [ttb_pkg::NUM_W-1:0] num_mag;
    logic [PW-1:0]            acc_abs;
    logic [DW:0]              rem2;
    logic                     qbit, load_out, out_free, last_cnt;
    logic signed [OW-1:0]     div_res, proj_res;
    logic signed [PW-1:0]     dot_shift;
    logic signed [AW-1:0]     e1_sel, e2_sel;
    logic signed [ttb_pkg::NRM_W-1:0] n_sel;

    // edge and normal component of the current lane
    always_comb
    begin
        case (term_reg) inside
            3'd1, 3'd4:
            begin
                e1_sel = AW'(rec_reg.e1_x);
                e2_sel = AW'(rec_reg.e2_x);
            end
            3'd2, 3'd5:
            begin
                e1_sel = AW'(rec_reg.e1_y);
                e2_sel = AW'(rec_reg.e2_y);
            end
            default:
            begin
                e1_sel = AW'(rec_reg.e1_z);
                e2_sel = AW'(rec_reg.e2_z);
            end
        endcase
        case (pidx_reg)
            2'd0:    n_sel = rec_reg.n_x;
            2'd1:    n_sel = rec_reg.n_y;
            default: n_sel = rec_reg.n_z;
        endcase
    end

    // select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ttb_pkg::ST_PMUL)
        begin
            mul_a = pass_reg ? d_reg : AW'(res_reg[res_idx]);
            mul_b = BW'(n_sel);
        end
        else if (term_reg == ttb_pkg::TERM_DET)
        begin
            mul_a = half_reg ? AW'(rec_reg.dv1) : AW'(rec_reg.du1);
            mul_b = half_reg ? rec_reg.du2 : rec_reg.dv2;
        end
        else if (term_reg < ttb_pkg::TERM_BIT0)
        begin
            mul_a = half_reg ? e2_sel : e1_sel;
            mul_b = half_reg ? rec_reg.dv1 : rec_reg.dv2;
        end
        else
        begin
            mul_a = half_reg ? e1_sel : e2_sel;
            mul_b = half_reg ? rec_reg.du2 : rec_reg.du1;
        end
    end

    assign prod_full = mul_a * mul_b;
    assign res_idx   = (state_reg == ttb_pkg::ST_PMUL || state_reg == ttb_pkg::ST_PACC)
                       ? {1'b0, pidx_reg} : term_reg - 3'd1;

    // numerator magnitude and divider step
    assign acc_abs  = acc_reg[PW-1] ? PW'(-acc_reg) : PW'(acc_reg);
    assign num_mag  = acc_abs[ttb_pkg::NUM_W-1:0];
    assign rem2     = {rem_reg, div_sh_reg[QW-1]};
    assign qbit     = (rem2 >= {1'b0, det_mag_reg});
    assign last_cnt = (cnt_reg == ttb_pkg::CNT_W'(QW - 1));

    // saturate the quotient with its sign
    always_comb
    begin
        if (num_neg_reg ^ det_neg_reg)
        begin
            if (ovf_reg || div_sh_reg > {1'b1, {(QW-1){1'b0}}})
                div_res = {1'b1, {(OW-1){1'b0}}};
            else
                div_res = OW'(-{1'b0, div_sh_reg});
        end
        else
        begin
            if (ovf_reg || div_sh_reg[QW-1])
                div_res = {1'b0, {(OW-1){1'b1}}};
            else
                div_res = OW'(div_sh_reg);
        end
    end

    // projection arithmetic
    assign dot_sum   = ((pidx_reg == 2'd0) ? '0 : acc_reg) + prod_reg;
    assign dot_shift = dot_sum >>> ttb_pkg::NORM_FRAC;
    assign corr      = prod_reg >>> ttb_pkg::NORM_FRAC;
    assign diff      = PW'(res_reg[res_idx]) - corr;
    always_comb
    begin
        if (diff > PW'(signed'({1'b0, {(OW-1){1'b1}}})))
            proj_res = {1'b0, {(OW-1){1'b1}}};
        else if (diff < -PW'(signed'({1'b0, {(OW-1){1'b1}}})) - PW'(1))
            proj_res = {1'b1, {(OW-1){1'b0}}};
        else
            proj_res = diff[OW-1:0];
    end

    assign out_free = !basis.valid || basis.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttb_pkg::ST_IDLE:
                if (!q_status.empty)
                    state_next = ttb_pkg::ST_MUL;
            ttb_pkg::ST_MUL:
                state_next = ttb_pkg::ST_ACC;
            ttb_pkg::ST_ACC:
                state_next = half_reg ? ttb_pkg::ST_EVAL : ttb_pkg::ST_MUL;
            ttb_pkg::ST_EVAL:
                if (term_reg == ttb_pkg::TERM_DET)
                    state_next = (acc_reg == '0) ? ttb_pkg::ST_OUT : ttb_pkg::ST_MUL;
                else if ({2'b0, num_mag} >= {det_mag_reg, {FR{1'b0}}})
                    state_next = ttb_pkg::ST_DIV_END;
                else
                    state_next = ttb_pkg::ST_DIV;
            ttb_pkg::ST_DIV:
                if (last_cnt)
                    state_next = ttb_pkg::ST_DIV_END;
            ttb_pkg::ST_DIV_END:
                state_next = (term_reg == ttb_pkg::TERM_LAST) ? ttb_pkg::ST_PMUL
                                                             : ttb_pkg::ST_MUL;
            ttb_pkg::ST_PMUL:
                state_next = ttb_pkg::ST_PACC;
            ttb_pkg::ST_PACC:
                state_next = (pass_reg && pidx_reg == 2'd2) ? ttb_pkg::ST_OUT
                                                           : ttb_pkg::ST_PMUL;
            ttb_pkg::ST_OUT:
                if (out_free)
                    state_next = ttb_pkg::ST_IDLE;
            default:
                state_next = ttb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop      = (state_reg == ttb_pkg::ST_IDLE) && !q_status.empty;
        load_out = (state_reg == ttb_pkg::ST_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ttb_pkg::ST_IDLE;
            basis.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                basis.valid <= 1'b1;
            else if (basis.ready)
                basis.valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttb_pkg::ST_IDLE:
            begin
                rec_reg   <= pop_rec;
                term_reg  <= ttb_pkg::TERM_DET;
                half_reg  <= 1'b0;
                degen_reg <= 1'b0;
                pidx_reg  <= 2'd0;
                pass_reg  <= 1'b0;
            end
            ttb_pkg::ST_MUL:
                prod_reg <= prod_full;
            ttb_pkg::ST_ACC:
            begin
                acc_reg  <= half_reg ? acc_reg - prod_reg : prod_reg;
                half_reg <= !half_reg;
            end
            ttb_pkg::ST_EVAL:
            begin
                if (term_reg == ttb_pkg::TERM_DET)
                begin
                    det_mag_reg <= acc_abs[DW-1:0];
                    det_neg_reg <= acc_reg[PW-1];
                    degen_reg   <= (acc_reg == '0);
                    term_reg    <= term_reg + 3'd1;
                end
                else
                begin
                    num_neg_reg <= acc_reg[PW-1];
                    ovf_reg     <= ({2'b0, num_mag} >= {det_mag_reg, {FR{1'b0}}});
                    rem_reg     <= DW'(num_mag[ttb_pkg::NUM_W-1:FR]);
                    div_sh_reg  <= {num_mag[FR-1:0], {(QW-FR){1'b0}}};
                    cnt_reg     <= '0;
                end
            end
            ttb_pkg::ST_DIV:
            begin
                rem_reg    <= qbit ? DW'(rem2 - {1'b0, det_mag_reg}) : DW'(rem2);
                div_sh_reg <= {div_sh_reg[QW-2:0], qbit};
                cnt_reg    <= cnt_reg + ttb_pkg::CNT_W'(1);
            end
            ttb_pkg::ST_DIV_END:
            begin
                res_reg[res_idx] <= div_res;
                if (term_reg != ttb_pkg::TERM_LAST)
                    term_reg <= term_reg + 3'd1;
            end
            ttb_pkg::ST_PMUL:
                prod_reg <= prod_full;
            ttb_pkg::ST_PACC:
            begin
                if (!pass_reg)
                begin
                    acc_reg <= dot_sum;
                    if (pidx_reg == 2'd2)
                    begin
                        d_reg    <= dot_shift[AW-1:0];
                        pass_reg <= 1'b1;
                        pidx_reg <= 2'd0;
                    end
                    else
                        pidx_reg <= pidx_reg + 2'd1;
                end
                else
                begin
                    res_reg[res_idx] <= proj_res;
                    pidx_reg         <= pidx_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // hold the result for the receiver
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            basis.degenerate  <= degen_reg;
            basis.tangent_x   <= degen_reg ? '0 : res_reg[0];
            basis.tangent_y   <= degen_reg ? '0 : res_reg[1];
            basis.tangent_z   <= degen_reg ? '0 : res_reg[2];
            basis.bitangent_x <= degen_reg ? '0 : res_reg[3];
            basis.bitangent_y <= degen_reg ? '0 : res_reg[4];
            basis.bitangent_z <= degen_reg ? '0 : res_reg[5];
        end
    end

endmodule

`default_nettype wire

FILE: design/triangle_tangent_basis.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent
// Takes triangle corners and gives one basis item for every third corner.
// ----------------------------------------------------------------------------
// Use:
//   corner: one triangle corner per item (position Q16.16, UV Q2.16,
//   unit normal Q2.14). Corners come in groups of three; the first two are
//   held, the third closes the triangle and is queued for the sequencer.
//   basis: one item per triangle: tangent with the third normal removed,
//   bitangent, and a degenerate flag (zero vectors) when the UV determinant
//   is zero. Values saturate to 32 bits.
// Timing:
//   Corners are taken one per cycle while the two-entry triangle queue has
//   room. Each triangle, from leaving the queue to loading the output
//   register, runs 14 products through one shared multiplier, six quotients
//   through a one-bit-per-cycle divider (skipped when the quotient saturates
//   outright), 6 projection products, and one step each to take the
//   triangle, test the determinant and load the output. Degenerate
//   triangles finish after the determinant.
// Reset: clears the corner position, the queue and the output valid.
// Stall: the output register holds while basis.ready is low; the sequencer
//   waits, then the queue fills, then the closing corner is held off.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_basis (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttb_corner_if.sink  corner,
    ttb_basis_if.source basis
);

    ttb_pkg::tri_rec_t  push_rec, pop_rec;
    ttb_pkg::q_status_t q_status;
    logic               push, pop;

    ttb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .corner   (corner),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    ttb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .q_status (q_status)
    );

    ttb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_rec  (pop_rec),
        .pop      (pop),
        .basis    (basis)
    );

`ifndef SYNTHESIS
    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("triangle pushed into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("triangle popped from empty queue");

    // a degenerate triangle carries zero vectors
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (basis.valid && basis.degenerate) |->
        (basis.tangent_x == '0 && basis.tangent_y == '0 && basis.tangent_z == '0 &&
         basis.bitangent_x == '0 && basis.bitangent_y == '0 &&
         basis.bitangent_z == '0))
        else $error("degenerate item with nonzero vectors");
`endif

endmodule

`default_nettype wire

FILE: bench/triangle_tangent_basis_test.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_test: self-checking bench of the tangent basis block
// Feeds corner items through a driver queue and predicts one basis item per
// third corner, compared field by field at the output under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_basis_test;

    typedef struct packed {
        logic signed [ttb_pkg::POS_W-1:0] px, py, pz;
        logic signed [ttb_pkg::UV_W-1:0]  u, v;
        logic signed [ttb_pkg::NRM_W-1:0] nx, ny, nz;
    } corner_item_t;

    typedef struct packed {
        logic signed [ttb_pkg::OUT_W-1:0] tx, ty, tz, bx, by, bz;
        logic                             degen;
    } basis_item_t;

    localparam longint LIMIT = 64'd4000000;

    logic clk;
    logic rst_n;
    ttb_corner_if corner ();
    ttb_basis_if  basis ();

    triangle_tangent_basis u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .corner (corner.sink),
        .basis  (basis.source)
    );

    corner_item_t pending_corners[$];
    basis_item_t  expected_bases[$];
    int           error_count;
    longint       cycle_count;
    bit           quiet_tail;
    bit           hold_request;
    int           hold_cycles;
    bit           corner_taken;

    // predictor state
    ttb_pkg::corner_t   pred_corner;
    logic signed [63:0] held_pos[6];
    logic signed [63:0] held_uv[4];

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got,
                 want, cycle_count);
    endtask

    // sign * floor(|num| * 2^16 / |den|), saturated to 32 bits
    function automatic logic signed [63:0] quotient_sat(input logic signed [63:0] num,
                                                        input logic signed [63:0] den);
        logic        neg;
        logic [63:0] n, d, q, r;
        logic        sat;
        logic [63:0] lim;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        lim = 64'd1 << 31;
        q = n / d;
        r = n % d;
        sat = q > lim;
        for (int i = 0; i < ttb_pkg::UV_FRAC; i++)
        begin
            if (!sat)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q + 1;
                end
                if (q > lim)
                    sat = 1'b1;
            end
        end
        if (neg)
            return sat ? -64'sd2147483648 : -$signed(q);
        if (sat || q > lim - 1)
            return 64'sd2147483647;
        return $signed(q);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // one corner into the predictor; a closing corner queues a basis item
    task automatic predict_basis(input corner_item_t c);
        logic signed [63:0] p[3], nrm[3], e1[3], e2[3], t[3], b[3];
        logic signed [63:0] du1, dv1, du2, dv2, det, dot;
        basis_item_t        res;
        p[0] = c.px;
        p[1] = c.py;
        p[2] = c.pz;
        nrm[0] = c.nx;
        nrm[1] = c.ny;
        nrm[2] = c.nz;
        if (pred_corner == ttb_pkg::CNR_SECOND)
        begin
            for (int k = 0; k < 3; k++)
                held_pos[3+k] = p[k];
            held_uv[2] = c.u;
            held_uv[3] = c.v;
            pred_corner = ttb_pkg::CNR_THIRD;
            return;
        end
        if (pred_corner != ttb_pkg::CNR_THIRD)
        begin
            for (int k = 0; k < 3; k++)
                held_pos[k] = p[k];
            held_uv[0] = c.u;
            held_uv[1] = c.v;
            pred_corner = ttb_pkg::CNR_SECOND;
            return;
        end
        pred_corner = ttb_pkg::CNR_FIRST;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = held_pos[3+k] - held_pos[k];
            e2[k] = p[k] - held_pos[k];
        end
        du1 = held_uv[2] - held_uv[0];
        dv1 = held_uv[3] - held_uv[1];
        du2 = 64'(c.u) - held_uv[0];
        dv2 = 64'(c.v) - held_uv[1];
        det = du1 * dv2 - dv1 * du2;
        res = '0;
        if (det == 0)
        begin
            res.degen = 1'b1;
            expected_bases = {expected_bases, res};
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            t[k] = quotient_sat(e1[k] * dv2 - e2[k] * dv1, det);
            b[k] = quotient_sat(e2[k] * du1 - e1[k] * du2, det);
        end
        // arithmetic shift floors toward minus infinity
        dot = (nrm[0] * t[0] + nrm[1] * t[1] + nrm[2] * t[2]) >>> ttb_pkg::NORM_FRAC;
        res.tx = 32'(clamp32(t[0] - ((nrm[0] * dot) >>> ttb_pkg::NORM_FRAC)));
        res.ty = 32'(clamp32(t[1] - ((nrm[1] * dot) >>> ttb_pkg::NORM_FRAC)));
        res.tz = 32'(clamp32(t[2] - ((nrm[2] * dot) >>> ttb_pkg::NORM_FRAC)));
        res.bx = 32'(b[0]);
        res.by = 32'(b[1]);
        res.bz = 32'(b[2]);
        expected_bases = {expected_bases, res};
    endtask

    // ------------------------------------------------------------------
    // driver: offer pending items, idle in bursts
    // ------------------------------------------------------------------
    int send_gap;

    // note whether the offered item was taken at this edge
    always @(posedge clk)
    begin
        corner_taken <= rst_n && corner.valid && corner.ready;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner.valid <= 1'b0;
            corner.pos_x <= '0;
            corner.pos_y <= '0;
            corner.pos_z <= '0;
            corner.tex_u <= '0;
            corner.tex_v <= '0;
            corner.norm_x <= '0;
            corner.norm_y <= '0;
            corner.norm_z <= '0;
            send_gap = 0;
        end
        else if (!corner.valid || corner_taken)
        begin
            if (!quiet_tail && send_gap == 0 && $urandom_range(0, 19) == 0)
                send_gap = $urandom_range(1, 17);
            if (send_gap > 0 || pending_corners.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                corner.valid <= 1'b0;
            end
            else
            begin
                corner_item_t c;
                c = pending_corners.pop_front();
                corner.valid <= 1'b1;
                corner.pos_x <= c.px;
                corner.pos_y <= c.py;
                corner.pos_z <= c.pz;
                corner.tex_u <= c.u;
                corner.tex_v <= c.v;
                corner.norm_x <= c.nx;
                corner.norm_y <= c.ny;
                corner.norm_z <= c.nz;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver ready: random bursts, long hold-off on request
    // ------------------------------------------------------------------
    int stall_gap;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis.ready <= 1'b0;
            stall_gap = 0;
            hold_cycles = 0;
        end
        else
        begin
            if (hold_request && hold_cycles == 0)
                hold_cycles = 3000;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                basis.ready <= 1'b0;
            end
            else
            begin
                if (!quiet_tail && stall_gap == 0 && $urandom_range(0, 15) == 0)
                    stall_gap = $urandom_range(1, 17);
                if (stall_gap > 0)
                begin
                    stall_gap--;
                    basis.ready <= 1'b0;
                end
                else
                    basis.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted corners, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && corner.valid && corner.ready)
            predict_basis({corner.pos_x, corner.pos_y, corner.pos_z, corner.tex_u,
                           corner.tex_v, corner.norm_x, corner.norm_y,
                           corner.norm_z});
        if (rst_n && basis.valid && basis.ready)
        begin
            if (expected_bases.size() == 0)
                report_mismatch("unexpected basis item", 0, 0);
            else
            begin
                basis_item_t w;
                w = expected_bases.pop_front();
                if (basis.tangent_x !== w.tx)
                    report_mismatch("tangent_x", basis.tangent_x, w.tx);
                if (basis.tangent_y !== w.ty)
                    report_mismatch("tangent_y", basis.tangent_y, w.ty);
                if (basis.tangent_z !== w.tz)
                    report_mismatch("tangent_z", basis.tangent_z, w.tz);
                if (basis.bitangent_x !== w.bx)
                    report_mismatch("bitangent_x", basis.bitangent_x, w.bx);
                if (basis.bitangent_y !== w.by)
                    report_mismatch("bitangent_y", basis.bitangent_y, w.by);
                if (basis.bitangent_z !== w.bz)
                    report_mismatch("bitangent_z", basis.bitangent_z, w.bz);
                if (basis.degenerate !== w.degen)
                    report_mismatch("degenerate", basis.degenerate, w.degen);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [17:0] rand_uv();
        case ($urandom_range(0, 5))
            0: return 18'($urandom());
            1: return $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
            2: return 18'($urandom_range(0, 3) * 16384);
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [15:0] rand_nrm();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic corner_item_t random_corner();
        corner_item_t c;
        c.px = rand_pos();
        c.py = rand_pos();
        c.pz = rand_pos();
        c.u = rand_uv();
        c.v = rand_uv();
        c.nx = rand_nrm();
        c.ny = rand_nrm();
        c.nz = rand_nrm();
        return c;
    endfunction

    task automatic add_corner(input logic [31:0] px, py, pz, input logic [17:0] u, v,
                              input logic [15:0] nx, ny, nz);
        pending_corners = {pending_corners, corner_item_t'({px, py, pz, u, v, nx, ny, nz})};
    endtask

    task automatic wait_drained();
        while (pending_corners.size() != 0 || corner.valid)
            @(posedge clk);
    endtask

    initial
    begin
        corner_item_t c;
        error_count = 0;
        cycle_count = 0;
        quiet_tail = 1'b0;
        hold_request = 1'b0;
        pred_corner = ttb_pkg::CNR_FIRST;
        for (int k = 0; k < 6; k++)
            held_pos[k] = 0;
        for (int k = 0; k < 4; k++)
            held_uv[k] = 0;

        // unit right triangle, normal along z
        add_corner(0, 0, 0, 0, 0, 0, 0, 16384);
        add_corner(32'h10000, 0, 0, 18'h10000, 0, 0, 0, 16384);
        add_corner(0, 32'h10000, 0, 0, 18'h10000, 0, 0, 16384);
        // zero UV determinant
        add_corner(5, 6, 7, 100, 100, 0, 0, 0);
        add_corner(9, 9, 9, 100, 100, 0, 0, 0);
        add_corner(1, 2, 3, 100, 100, 0, 0, 0);
        // extreme positions, tiny determinant: saturation both ways
        add_corner(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0);
        add_corner(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0, 16'h7fff, 16'h8000, 0);
        add_corner(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 1, 16'h8000,
                   16'h7fff, 16'h7fff);
        // extreme UV span and normals
        add_corner(32'h12345678, 32'hedcba987, 32'h0, 18'h20000, 18'h1ffff, 0, 0, 0);
        add_corner(32'hffffffff, 32'h1, 32'h55555555, 18'h1ffff, 18'h20000, 0, 0, 0);
        add_corner(32'haaaaaaaa, 32'h0, 32'h7fffffff, 18'h20000, 18'h20000,
                   16'hffff, 16'h8000, 16'h7fff);
        // negative determinant
        add_corner(0, 0, 0, 0, 0, 0, 0, 0);
        add_corner(32'h30000, 32'h10000, 0, 0, 18'h8000, 0, 0, 0);
        add_corner(0, 32'h20000, 32'h40000, 18'h8000, 0, 16384, 0, 0);

        // random triangles
        for (int i = 0; i < 280; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c = random_corner();
                if ($urandom_range(0, 15) == 0 && k > 0)
                begin
                    c.u = pending_corners[$].u;
                    c.v = pending_corners[$].v;
                end
                pending_corners = {pending_corners, c};
            end
            // long receiver hold-off while the sender keeps going
            if (i == 100)
            begin
                wait_drained();
                hold_request = 1'b1;
                @(posedge clk);
                hold_request = 1'b0;
            end
        end
        wait_drained();
        quiet_tail = 1'b1;
        for (int i = 0; i < 12; i++)
            pending_corners = {pending_corners, random_corner()};
        wait_drained();

        while (expected_bases.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
